/* src/ognms_pkg.sv */
// ognms_pkg: types, constants and the overlap helper of the overlap group NMS block.
// Has no dependencies; every other file of the block uses it.
package ognms_pkg;

  localparam int MaxGroups  = 16;
  localparam int MaxMembers = 16;
  localparam int CoordBits  = 11;
  localparam int SideBits   = 6;
  localparam int ScoreBits  = 16;

  localparam logic [5:0]  MaxSideReset = 6'd60;
  localparam logic [11:0] ImgWidthReset  = 12'd640;
  localparam logic [11:0] ImgHeightReset = 12'd480;

  localparam logic [1:0] CFG_MAX_SIDE  = 2'd0;
  localparam logic [1:0] CFG_IMG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_IMG_HEIGHT = 2'd2;

  localparam logic KIND_BOX = 1'b0;
  localparam logic KIND_EOF = 1'b1;

  typedef struct packed {
    logic                        kind;
    logic [CoordBits-1:0]        box_x;
    logic [CoordBits-1:0]        box_y;
    logic [CoordBits-1:0]        box_width;
    logic [CoordBits-1:0]        box_height;
    logic                        is_positive;
    logic signed [ScoreBits-1:0] score;
  } in_t;

  typedef struct packed {
    logic                 valid_res;
    logic [CoordBits-1:0] out_x;
    logic [CoordBits-1:0] out_y;
    logic [SideBits-1:0]  out_width;
    logic [SideBits-1:0]  out_height;
    logic [4:0]           group_size;
    logic                 overflowed;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic [5:0]  max_side;
    logic [11:0] image_width;
    logic [11:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [CoordBits-1:0]        x;
    logic [CoordBits-1:0]        y;
    logic [SideBits-1:0]         side;
    logic signed [ScoreBits-1:0] score;
  } member_t;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [SideBits-1:0]  w;
    logic [SideBits-1:0]  h;
  } cur_t;

  typedef struct packed {
    logic                 hit;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [SideBits-1:0]  w;
    logic [SideBits-1:0]  h;
  } ovl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRP_RD,
    ST_GRP_CMP,
    ST_SEL_RD,
    ST_SEL_CMP,
    ST_CUR_RD,
    ST_CUR_LD,
    ST_MRG_RD,
    ST_MRG_CMP,
    ST_EMIT
  } state_e;

  // intersection of two boxes; hit means nonzero area
  function automatic ovl_t overlap(input cur_t a, input cur_t b);
    logic [CoordBits-1:0] lx;
    logic [CoordBits-1:0] ty;
    logic [CoordBits:0]   ar;
    logic [CoordBits:0]   br;
    logic [CoordBits:0]   ab;
    logic [CoordBits:0]   bb;
    logic [CoordBits:0]   rx;
    logic [CoordBits:0]   by;
    ovl_t r;
    lx = (a.x > b.x) ? a.x : b.x;
    ty = (a.y > b.y) ? a.y : b.y;
    ar = (CoordBits+1)'(a.x) + (CoordBits+1)'(a.w);
    br = (CoordBits+1)'(b.x) + (CoordBits+1)'(b.w);
    ab = (CoordBits+1)'(a.y) + (CoordBits+1)'(a.h);
    bb = (CoordBits+1)'(b.y) + (CoordBits+1)'(b.h);
    rx = (ar < br) ? ar : br;
    by = (ab < bb) ? ab : bb;
    r.hit = ((CoordBits+1)'(lx) < rx) && ((CoordBits+1)'(ty) < by);
    r.x = lx;
    r.y = ty;
    r.w = SideBits'(rx - (CoordBits+1)'(lx));
    r.h = SideBits'(by - (CoordBits+1)'(ty));
    return r;
  endfunction

endpackage

/* src/ognms_cfg.sv */
// ognms_cfg: configuration registers written over the valid/ready write channel.
// Depends on ognms_pkg.
module ognms_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i,
  output ognms_pkg::cfg_t     cfg_o
);

  ognms_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ognms_pkg::CFG_MAX_SIDE:   cfg_d.max_side     = cfg_data_i[5:0];
        ognms_pkg::CFG_IMG_WIDTH:  cfg_d.image_width  = cfg_data_i;
        ognms_pkg::CFG_IMG_HEIGHT: cfg_d.image_height = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_side     <= ognms_pkg::MaxSideReset;
      cfg_q.image_width  <= ognms_pkg::ImgWidthReset;
      cfg_q.image_height <= ognms_pkg::ImgHeightReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/ognms_store.sv */
// ognms_store: member store, one write and one registered read port.
// Depends on ognms_pkg.
module ognms_store #(
  parameter int AW = 8
) (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output ognms_pkg::member_t   rdata_o,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  ognms_pkg::member_t   wdata_i
);

  ognms_pkg::member_t mem [2**AW];
  ognms_pkg::member_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ognms_seq.sv */
// ognms_seq: sequencer for grouping, best-member selection, merging and result output.
// Depends on ognms_pkg; drives the ognms_store ports.
module ognms_seq #(
  parameter int MAX_GROUPS  = ognms_pkg::MaxGroups,
  parameter int MAX_MEMBERS = ognms_pkg::MaxMembers,
  parameter int GW = 4,
  parameter int KW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ognms_pkg::cfg_t      cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ognms_pkg::in_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ognms_pkg::out_t      out_data_o,
  output logic                 re_o,
  output logic [GW+KW-1:0]     raddr_o,
  input  ognms_pkg::member_t   rdata_i,
  output logic                 we_o,
  output logic [GW+KW-1:0]     waddr_o,
  output ognms_pkg::member_t   wdata_o
);

  localparam int FW = $clog2(MAX_MEMBERS + 1);
  localparam int TW = $clog2(MAX_GROUPS + 1);
  localparam int CB = ognms_pkg::CoordBits;
  localparam int SB = ognms_pkg::SideBits;

  ognms_pkg::state_e state_q, state_d;
  logic [GW-1:0]           g_q, g_d;
  logic [KW-1:0]           k_q, k_d;
  logic [KW-1:0]           best_q, best_d;
  logic signed [15:0]      low_q, low_d;
  ognms_pkg::member_t      nb_q, nb_d;
  ognms_pkg::cur_t         cur_q, cur_d;
  logic [FW-1:0]           fill_q [MAX_GROUPS];
  logic [FW-1:0]           fill_d [MAX_GROUPS];
  logic [TW-1:0]           total_q, total_d;
  logic                    ovf_q, ovf_d;
  ognms_pkg::out_t         out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic            in_accept;
  logic            is_eof;
  logic [CB-1:0]   side;
  logic [CB:0]     x_end;
  logic [CB:0]     y_end;
  logic            keep;
  logic [FW-1:0]   fill_g;
  logic            last_k;
  logic            last_g;
  logic            slot_free;
  logic            group_full;
  logic            groups_full;
  ognms_pkg::cur_t nb_box;
  ognms_pkg::cur_t rd_box;
  ognms_pkg::ovl_t grp_ovl;
  ognms_pkg::ovl_t mrg_ovl;
  logic [11:0]     area_ov;
  logic [11:0]     area_cur;
  logic [11:0]     area_mem;
  logic [13:0]     lhs;
  logic [13:0]     rhs;
  logic            merge;

  assign in_stall_o  = (state_q != ognms_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign is_eof      = (in_data_i.kind == ognms_pkg::KIND_EOF);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  assign side  = (in_data_i.box_width > in_data_i.box_height) ?
                 in_data_i.box_width : in_data_i.box_height;
  assign x_end = (CB+1)'(in_data_i.box_x) + (CB+1)'(side);
  assign y_end = (CB+1)'(in_data_i.box_y) + (CB+1)'(side);
  assign keep  = (side < CB'(cfg_i.max_side)) &&
                 (12'(y_end) < cfg_i.image_height) &&
                 (12'(x_end) < cfg_i.image_width) &&
                 in_data_i.is_positive;

  assign fill_g      = fill_q[g_q];
  assign last_k      = (FW'(k_q) == fill_g - FW'(1));
  assign last_g      = (TW'(g_q) == total_q - TW'(1));
  assign group_full  = (fill_g >= FW'(MAX_MEMBERS));
  assign groups_full = (total_q >= TW'(MAX_GROUPS));

  assign nb_box = '{x: nb_q.x, y: nb_q.y, w: nb_q.side, h: nb_q.side};
  assign rd_box = '{x: rdata_i.x, y: rdata_i.y, w: rdata_i.side, h: rdata_i.side};
  assign grp_ovl = ognms_pkg::overlap(nb_box, rd_box);
  assign mrg_ovl = ognms_pkg::overlap(cur_q, rd_box);

  assign area_ov  = 12'(mrg_ovl.w) * 12'(mrg_ovl.h);
  assign area_cur = 12'(cur_q.w) * 12'(cur_q.h);
  assign area_mem = 12'(rdata_i.side) * 12'(rdata_i.side);
  assign lhs      = 14'(3) * 14'(area_ov);
  assign rhs      = 14'(area_cur) + 14'(area_mem);
  assign merge    = mrg_ovl.hit && (lhs > rhs);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ognms_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (is_eof) begin
            state_d = (total_q == '0) ? ognms_pkg::ST_EMIT : ognms_pkg::ST_SEL_RD;
          end else if (keep && (total_q != '0)) begin
            state_d = ognms_pkg::ST_GRP_RD;
          end
        end
      end
      ognms_pkg::ST_GRP_RD: state_d = ognms_pkg::ST_GRP_CMP;
      ognms_pkg::ST_GRP_CMP: begin
        if (grp_ovl.hit || (last_k && last_g)) begin
          state_d = ognms_pkg::ST_IDLE;
        end else begin
          state_d = ognms_pkg::ST_GRP_RD;
        end
      end
      ognms_pkg::ST_SEL_RD: state_d = ognms_pkg::ST_SEL_CMP;
      ognms_pkg::ST_SEL_CMP: begin
        state_d = last_k ? ognms_pkg::ST_CUR_RD : ognms_pkg::ST_SEL_RD;
      end
      ognms_pkg::ST_CUR_RD: state_d = ognms_pkg::ST_CUR_LD;
      ognms_pkg::ST_CUR_LD: begin
        state_d = (fill_g == FW'(1)) ? ognms_pkg::ST_EMIT : ognms_pkg::ST_MRG_RD;
      end
      ognms_pkg::ST_MRG_RD: begin
        if (k_q != best_q) begin
          state_d = ognms_pkg::ST_MRG_CMP;
        end else if (last_k) begin
          state_d = ognms_pkg::ST_EMIT;
        end
      end
      ognms_pkg::ST_MRG_CMP: begin
        state_d = last_k ? ognms_pkg::ST_EMIT : ognms_pkg::ST_MRG_RD;
      end
      ognms_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_d = ((total_q == '0) || last_g) ? ognms_pkg::ST_IDLE : ognms_pkg::ST_SEL_RD;
        end
      end
      default: state_d = ognms_pkg::ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    g_d         = g_q;
    k_d         = k_q;
    best_d      = best_q;
    low_d       = low_q;
    nb_d        = nb_q;
    cur_d       = cur_q;
    fill_d      = fill_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    re_o        = 1'b0;
    raddr_o     = {g_q, k_q};
    we_o        = 1'b0;
    waddr_o     = {g_q, fill_g[KW-1:0]};
    wdata_o     = nb_q;

    case (state_q)
      ognms_pkg::ST_IDLE: begin
        if (in_accept) begin
          nb_d.x     = in_data_i.box_x;
          nb_d.y     = in_data_i.box_y;
          nb_d.side  = SB'(side);
          nb_d.score = in_data_i.score;
          g_d        = '0;
          k_d        = '0;
          best_d     = '0;
          low_d      = '0;
          if (!is_eof && keep && (total_q == '0)) begin
            we_o          = 1'b1;
            waddr_o       = '0;
            wdata_o.x     = in_data_i.box_x;
            wdata_o.y     = in_data_i.box_y;
            wdata_o.side  = SB'(side);
            wdata_o.score = in_data_i.score;
            fill_d[0]     = FW'(1);
            total_d       = TW'(1);
          end
        end
      end
      ognms_pkg::ST_GRP_RD: re_o = 1'b1;
      ognms_pkg::ST_GRP_CMP: begin
        if (grp_ovl.hit) begin
          if (group_full) begin
            ovf_d = 1'b1;
          end else begin
            we_o        = 1'b1;
            fill_d[g_q] = fill_g + FW'(1);
          end
        end else if (last_k) begin
          k_d = '0;
          if (last_g) begin
            if (groups_full) begin
              ovf_d = 1'b1;
            end else begin
              we_o                    = 1'b1;
              waddr_o                 = {total_q[GW-1:0], {KW{1'b0}}};
              fill_d[total_q[GW-1:0]] = FW'(1);
              total_d                 = total_q + TW'(1);
            end
          end else begin
            g_d = g_q + GW'(1);
          end
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ognms_pkg::ST_SEL_RD: re_o = 1'b1;
      ognms_pkg::ST_SEL_CMP: begin
        if (rdata_i.score < low_q) begin
          low_d  = rdata_i.score;
          best_d = k_q;
        end
        k_d = last_k ? '0 : k_q + KW'(1);
      end
      ognms_pkg::ST_CUR_RD: begin
        re_o    = 1'b1;
        raddr_o = {g_q, best_q};
      end
      ognms_pkg::ST_CUR_LD: begin
        cur_d = rd_box;
        k_d   = '0;
      end
      ognms_pkg::ST_MRG_RD: begin
        if (k_q != best_q) begin
          re_o = 1'b1;
        end else if (!last_k) begin
          k_d = k_q + KW'(1);
        end
      end
      ognms_pkg::ST_MRG_CMP: begin
        if (merge) begin
          cur_d = '{x: mrg_ovl.x, y: mrg_ovl.y, w: mrg_ovl.w, h: mrg_ovl.h};
        end
        if (!last_k) begin
          k_d = k_q + KW'(1);
        end
      end
      ognms_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d.overflowed = ovf_q;
          if (total_q == '0) begin
            out_d.valid_res  = 1'b0;
            out_d.out_x      = '0;
            out_d.out_y      = '0;
            out_d.out_width  = '0;
            out_d.out_height = '0;
            out_d.group_size = '0;
            out_d.last       = 1'b1;
          end else begin
            out_d.valid_res  = 1'b1;
            out_d.out_x      = cur_q.x;
            out_d.out_y      = cur_q.y;
            out_d.out_width  = cur_q.w;
            out_d.out_height = cur_q.h;
            out_d.group_size = 5'(fill_g);
            out_d.last       = last_g;
          end
          if ((total_q == '0) || last_g) begin
            for (int i = 0; i < MAX_GROUPS; i++) begin
              fill_d[i] = '0;
            end
            total_d = '0;
            ovf_d   = 1'b0;
          end else begin
            g_d    = g_q + GW'(1);
            k_d    = '0;
            best_d = '0;
            low_d  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ognms_pkg::ST_IDLE;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q    <= g_d;
    k_q    <= k_d;
    best_q <= best_d;
    low_q  <= low_d;
    nb_q   <= nb_d;
    cur_q  <= cur_d;
    out_q  <= out_d;
  end

endmodule

/* src/overlap_group_nms.sv */
// overlap_group_nms: top level; groups boxes of a frame by overlap, one merged box per group.
// Depends on ognms_pkg, ognms_cfg, ognms_store and ognms_seq.
//
//   channel  signals                          direction  transaction when
//   in       in_valid_i in_stall_o in_data_i  sink       valid && !stall
//   out      out_valid_o out_stall_i out_data_o source   valid && !stall
//   cfg      cfg_valid_i cfg_ready_o idx data sink       valid && ready
//
// Candidate box: accepted in idle, then one store read and one compare for each stored member scanned.
// End of frame: per group a score scan, a best-member read, a merge pass (skipped when the
// group has one member) and an emit, each result waiting while out_stall_i holds the
// output register full.
// Empty frame: straight to emit. Reset clears fill counts, group count and overflow flag at once.
// in_stall_o is high whenever the sequencer is busy.
module overlap_group_nms #(
  parameter int MAX_GROUPS  = ognms_pkg::MaxGroups,
  parameter int MAX_MEMBERS = ognms_pkg::MaxMembers
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ognms_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ognms_pkg::out_t  out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [11:0]      cfg_data_i
);

  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int KW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

  ognms_pkg::cfg_t    cfg;
  logic               re;
  logic [GW+KW-1:0]   raddr;
  ognms_pkg::member_t rdata;
  logic               we;
  logic [GW+KW-1:0]   waddr;
  ognms_pkg::member_t wdata;

  ognms_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ognms_store #(
    .AW (GW + KW)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  ognms_seq #(
    .MAX_GROUPS  (MAX_GROUPS),
    .MAX_MEMBERS (MAX_MEMBERS),
    .GW          (GW),
    .KW          (KW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata)
  );

endmodule
